// ===== hdl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parser and websocket_frame_deframer.
`default_nettype none

package wsd_pkg;

  // Values of the 7-bit length field that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [7:0] LEN_MASK  = 8'h7F;

  // Count of extended length and key bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_in_frame;
    logic       empty_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/wsd_parser.sv =====
// Header parser and payload unmasking for the deframer.
// Depends on wsd_pkg; one state update per accepted byte.
`default_nettype none

module wsd_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_en,
  input  wire logic [7:0]       data_byte,
  output logic                  res_valid,
  output wsd_pkg::result_t      res
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_on_r, mask_on_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;

  logic [6:0]  len7;
  logic [63:0] ext_shift;
  logic [7:0]  key_byte;

  assign len7      = data_byte[6:0] & wsd_pkg::LEN_MASK[6:0];
  assign ext_shift = {remain_r[55:0], data_byte};

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    mask_on_nxt = mask_on_r;
    hdr_cnt_nxt = hdr_cnt_r;
    remain_nxt  = remain_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    res_valid   = 1'b0;
    res.payload_byte   = 8'd0;
    res.frame_opcode   = opcode_r;
    res.final_fragment = fin_r;
    res.last_in_frame  = 1'b0;
    res.empty_frame    = 1'b0;

    if (byte_en) begin
      case (phase_r)
        wsd_pkg::PH_HDR1: begin
          mask_on_nxt = data_byte[7];
          key_nxt     = 32'd0;
          remain_nxt  = 64'd0;
          if (len7 == wsd_pkg::LEN_EXT16) begin
            hdr_cnt_nxt = wsd_pkg::EXT16_BYTES;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else if (len7 == wsd_pkg::LEN_EXT64) begin
            hdr_cnt_nxt = wsd_pkg::EXT64_BYTES;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else begin
            remain_nxt = {57'd0, len7};
            if (data_byte[7]) begin
              hdr_cnt_nxt = wsd_pkg::KEY_BYTES;
              phase_nxt   = wsd_pkg::PH_KEY;
            end else begin
              key_idx_nxt = 2'd0;
              hdr_cnt_nxt = 4'd0;
              if (len7 == 7'd0) begin
                phase_nxt         = wsd_pkg::PH_HDR0;
                res_valid         = 1'b1;
                res.last_in_frame = 1'b1;
                res.empty_frame   = 1'b1;
              end else begin
                phase_nxt = wsd_pkg::PH_DATA;
              end
            end
          end
        end

        wsd_pkg::PH_EXT: begin
          remain_nxt  = ext_shift;
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_r == 4'd1) begin
            if (mask_on_r) begin
              hdr_cnt_nxt = wsd_pkg::KEY_BYTES;
              phase_nxt   = wsd_pkg::PH_KEY;
            end else begin
              key_idx_nxt = 2'd0;
              hdr_cnt_nxt = 4'd0;
              if (ext_shift == 64'd0) begin
                phase_nxt         = wsd_pkg::PH_HDR0;
                res_valid         = 1'b1;
                res.last_in_frame = 1'b1;
                res.empty_frame   = 1'b1;
              end else begin
                phase_nxt = wsd_pkg::PH_DATA;
              end
            end
          end
        end

        wsd_pkg::PH_KEY: begin
          key_nxt     = {key_r[23:0], data_byte};
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_r == 4'd1) begin
            key_idx_nxt = 2'd0;
            hdr_cnt_nxt = 4'd0;
            if (remain_r == 64'd0) begin
              phase_nxt         = wsd_pkg::PH_HDR0;
              res_valid         = 1'b1;
              res.last_in_frame = 1'b1;
              res.empty_frame   = 1'b1;
            end else begin
              phase_nxt = wsd_pkg::PH_DATA;
            end
          end
        end

        wsd_pkg::PH_DATA: begin
          key_idx_nxt      = key_idx_r + 2'd1;
          remain_nxt       = remain_r - 64'd1;
          res_valid        = 1'b1;
          res.payload_byte = data_byte ^ key_byte;
          // remain_r is never zero here, so one left means this is the last
          if (remain_r == 64'd1) begin
            phase_nxt         = wsd_pkg::PH_HDR0;
            res.last_in_frame = 1'b1;
          end
        end

        default: begin
          fin_nxt    = data_byte[7];
          opcode_nxt = data_byte[3:0];
          phase_nxt  = wsd_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsd_pkg::PH_HDR0;
      fin_r     <= 1'b0;
      opcode_r  <= 4'd0;
      mask_on_r <= 1'b0;
      hdr_cnt_r <= 4'd0;
      remain_r  <= 64'd0;
      key_r     <= 32'd0;
      key_idx_r <= 2'd0;
    end else begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      opcode_r  <= opcode_nxt;
      mask_on_r <= mask_on_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      remain_r  <= remain_nxt;
      key_r     <= key_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser plus output skid stage.
// Depends on wsd_pkg and wsd_parser.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) carries the raw frame
//   stream, one byte per beat, frames back to back. Output channel
//   (out_valid / out_stall / out_*) carries one beat per payload byte,
//   unmasked, tagged with the frame's opcode and fin bit; last_in_frame marks
//   the final payload byte. A frame with no payload gives one empty marker
//   beat (payload zero, last and empty set) when its header completes.
//   Header bytes otherwise give no output beat.
//   Results are registered in the output register, or the skid register if
//   that is full and stalled. Throughput: one byte per cycle while in_stall
//   is low, set by the parser update (64-bit length decrement and compare).
//   Reset (synchronous, rst_n low) returns the parser to expect the first
//   header byte of a new frame and empties the output stage.
//   When the receiver stalls, the output register holds its beat and one
//   further result lands in the skid register; in_stall then rises and
//   holds until the skid beat moves to the output register.
`default_nettype none

module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_final_fragment,
  output logic            out_last_in_frame,
  output logic            out_empty_frame
);

  logic             in_take;
  logic             out_take;
  logic             res_valid;
  wsd_pkg::result_t res;

  // Output register and skid register; the skid is full only while the
  // output register is full and stalled.
  logic             out_v_r;
  wsd_pkg::result_t out_r;
  logic             skid_v_r;
  wsd_pkg::result_t skid_r;

  // Stall input whenever the skid holds a beat: one more result could be lost
  assign in_stall = skid_v_r;
  assign in_take  = in_valid & ~skid_v_r;
  assign out_take = out_v_r & ~out_stall;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_take),
    .data_byte (in_data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Control: valid flags of the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // Advance the skid beat once the output register frees up
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_take && res_valid) begin
      if (out_v_r && !out_take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_take && res_valid) begin
      if (out_v_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_final_fragment = out_r.final_fragment;
  assign out_last_in_frame  = out_r.last_in_frame;
  assign out_empty_frame    = out_r.empty_frame;

endmodule

`default_nettype wire

// ===== verif/websocket_frame_deframer_test.sv =====
// Self-checking testbench for websocket_frame_deframer: drives frame byte streams through the
// valid/stall channels and checks every output beat against an in-bench frame parser.
// Depends on wsd_pkg (result_t, phase_t, length codes) and the RTL of the deframer.
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

  localparam int CLK_HALF    = 1;
  localparam int RESET_CYCLES = 7;
  localparam int TIMEOUT_NS  = 200000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int IDLE_PCT    = 31;
  localparam int NUM_ROWS    = 29;

  // How the length of a generated frame is announced
  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  // One directed beat; want is only used where typed is set
  typedef struct packed {
    logic [7:0]       data;
    logic             typed;
    wsd_pkg::result_t want;
  } stim_row_t;

  localparam wsd_pkg::result_t NO_BEAT = '0;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic [3:0] out_frame_opcode;
  logic       out_final_fragment;
  logic       out_last_in_frame;
  logic       out_empty_frame;

  websocket_frame_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_last_in_frame  (out_last_in_frame),
    .out_empty_frame    (out_empty_frame)
  );

  always #(CLK_HALF) clk = ~clk;

  // Parser state mirrored in the bench
  wsd_pkg::phase_t st_phase;
  logic        st_fin;
  logic [3:0]  st_opcode;
  logic        st_masked;
  logic [3:0]  st_hdr_left;
  logic [63:0] st_remaining;
  logic [31:0] st_key;
  logic [1:0]  st_key_idx;

  wsd_pkg::result_t pending_beats[$];
  wsd_pkg::result_t oldest_beat;
  int      mismatch_count = 0;
  int      sent_bytes = 0;

  // Sender and receiver idling controls. Main flips rx flags at posedge only,
  // the stall process reads them at negedge.
  bit tx_gaps_on;
  bit rx_quiet;
  bit holdoff_req;
  int holdoff_left;

  // Directed stream: extremes of the header fields, every length form,
  // non-minimal extended lengths, zero-length frames, masked and unmasked headers, masked payload.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{8'h89, 1'b0, NO_BEAT},  // fin, ping opcode
    '{8'h00, 1'b1, {8'h00, 4'h9, 1'b1, 1'b1, 1'b1}},  // zero length: empty marker at once
    '{8'h70, 1'b0, NO_BEAT},  // fin clear, all reserved bits set, opcode 0
    '{8'hFF, 1'b0, NO_BEAT},  // masked, 64-bit length follows
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, NO_BEAT},  // non-minimal 64-bit length of one
    '{8'hFF, 1'b0, NO_BEAT},  // all-ones key
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, {8'hFF, 4'h0, 1'b0, 1'b1, 1'b0}},  // sole payload byte, inverted by key
    '{8'h8F, 1'b0, NO_BEAT},  // fin, opcode 15
    '{8'h7E, 1'b0, NO_BEAT},  // unmasked, 16-bit length follows
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, {8'h00, 4'hF, 1'b1, 1'b1, 1'b1}},  // extended length zero: empty marker
    '{8'h82, 1'b0, NO_BEAT},  // fin, binary
    '{8'h82, 1'b0, NO_BEAT},  // masked, length 2
    '{8'hA5, 1'b0, NO_BEAT},
    '{8'h5A, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, NO_BEAT},
    '{8'h80, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT}
  };

  task automatic reset_frame_parser();
    st_phase     = wsd_pkg::PH_HDR0;
    st_fin       = 1'b0;
    st_opcode    = 4'h0;
    st_masked    = 1'b0;
    st_hdr_left  = 4'd0;
    st_remaining = 64'd0;
    st_key       = 32'd0;
    st_key_idx   = 2'd0;
  endtask

  // Header complete: emit the empty marker or enter the payload
  task automatic close_header(output bit produced, output wsd_pkg::result_t r);
    st_key_idx  = 2'd0;
    st_hdr_left = 4'd0;
    if (st_remaining == 64'd0) begin
      st_phase = wsd_pkg::PH_HDR0;
      produced = 1'b1;
      r = {8'h00, st_opcode, st_fin, 1'b1, 1'b1};
    end else begin
      st_phase = wsd_pkg::PH_DATA;
    end
  endtask

  // Advance the bench parser by one input byte; report the beat it causes
  task automatic deframe_step(input logic [7:0] b, output bit produced,
                              output wsd_pkg::result_t r);
    logic [7:0] kb;
    produced = 1'b0;
    r = NO_BEAT;
    case (st_phase)
      wsd_pkg::PH_HDR1: begin
        st_masked    = b[7];
        st_key       = 32'd0;
        st_remaining = 64'd0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          st_hdr_left = wsd_pkg::EXT16_BYTES;
          st_phase    = wsd_pkg::PH_EXT;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          st_hdr_left = wsd_pkg::EXT64_BYTES;
          st_phase    = wsd_pkg::PH_EXT;
        end else begin
          st_remaining = 64'(b & wsd_pkg::LEN_MASK);
          if (st_masked) begin
            st_hdr_left = wsd_pkg::KEY_BYTES;
            st_phase    = wsd_pkg::PH_KEY;
          end else begin
            close_header(produced, r);
          end
        end
      end
      wsd_pkg::PH_EXT: begin
        st_remaining = {st_remaining[55:0], b};
        st_hdr_left  = st_hdr_left - 4'd1;
        if (st_hdr_left == 4'd0) begin
          if (st_masked) begin
            st_hdr_left = wsd_pkg::KEY_BYTES;
            st_phase    = wsd_pkg::PH_KEY;
          end else begin
            close_header(produced, r);
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        st_key      = {st_key[23:0], b};
        st_hdr_left = st_hdr_left - 4'd1;
        if (st_hdr_left == 4'd0) close_header(produced, r);
      end
      wsd_pkg::PH_DATA: begin
        kb           = st_key[8 * (3 - st_key_idx) +: 8];
        st_key_idx   = st_key_idx + 2'd1;
        st_remaining = st_remaining - 64'd1;
        produced     = 1'b1;
        r = {b ^ kb, st_opcode, st_fin, st_remaining == 64'd0, 1'b0};
        if (st_remaining == 64'd0) st_phase = wsd_pkg::PH_HDR0;
      end
      default: begin
        st_fin    = b[7];
        st_opcode = b[3:0];
        st_phase  = wsd_pkg::PH_HDR1;
      end
    endcase
  endtask

  // Offer one beat from a negedge, hold it until accepted, then queue what it causes.
  // Returns at the negedge after acceptance with in_valid still high.
  task automatic send_byte(input logic [7:0] b, input bit typed, input wsd_pkg::result_t want);
    bit               produced;
    wsd_pkg::result_t got;
    while (tx_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_step(b, produced, got);
    if (typed) pending_beats.push_back(want);
    else if (produced) pending_beats.push_back(got);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input bit masked, input len_form_t form,
                            input logic [63:0] len, input int n_payload);
    logic [6:0] code;
    code = (form == FORM_EXT16) ? wsd_pkg::LEN_EXT16 :
           (form == FORM_EXT64) ? wsd_pkg::LEN_EXT64 : len[6:0];
    send_byte(first, 1'b0, NO_BEAT);
    send_byte({masked, code}, 1'b0, NO_BEAT);
    if (form == FORM_EXT16)
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0, NO_BEAT);
    if (form == FORM_EXT64)
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0, NO_BEAT);
    if (masked)
      repeat (4) send_byte(8'($urandom), 1'b0, NO_BEAT);
    repeat (n_payload) send_byte(8'($urandom), 1'b0, NO_BEAT);
  endtask

  // Raw noise byte; keep the upper extended-length bytes zero so a garbage
  // header never announces a payload too long to finish
  function automatic logic [7:0] noise_byte();
    if (st_phase == wsd_pkg::PH_EXT && st_hdr_left > 4'd1) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_random_frame();
    int          pick;
    logic [63:0] len;
    len_form_t   form;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise run, then finish whatever frame it opened
      repeat ($urandom_range(1, 12)) send_byte(noise_byte(), 1'b0, NO_BEAT);
      while (st_phase != wsd_pkg::PH_HDR0) send_byte(noise_byte(), 1'b0, NO_BEAT);
    end else begin
      if (pick < 50) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(0, 12));
      end else if (pick < 62) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(0, 125));
      end else if (pick < 80) begin
        form = FORM_EXT16;
        len  = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(126, 300))
                                          : 64'($urandom_range(0, 24));
      end else begin
        form = FORM_EXT64;
        len  = 64'($urandom_range(0, 16));
      end
      send_frame(8'($urandom), 1'($urandom), form, len, int'(len));
    end
  endtask

  // Drop valid, then change receiver behavior on a posedge so the stall
  // process, which runs at negedge, sees it without a race
  task automatic rx_mode(input bit quiet, input bit holdoff);
    in_valid <= 1'b0;
    @(posedge clk);
    rx_quiet    = quiet;
    holdoff_req = holdoff;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every queued beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stall, a counted hold-off on request, or no stall at all
  initial begin
    out_stall    = 1'b0;
    holdoff_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Scoreboard: compare each accepted output beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("output beat with nothing expected: payload_byte %0h", out_payload_byte);
        mismatch_count++;
      end else begin
        oldest_beat = pending_beats.pop_front();
        check_field("payload_byte", oldest_beat.payload_byte, out_payload_byte);
        check_field("frame_opcode", 8'(oldest_beat.frame_opcode), 8'(out_frame_opcode));
        check_field("final_fragment", 8'(oldest_beat.final_fragment), 8'(out_final_fragment));
        check_field("last_in_frame", 8'(oldest_beat.last_in_frame), 8'(out_last_in_frame));
        check_field("empty_frame", 8'(oldest_beat.empty_frame), 8'(out_empty_frame));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("websocket_frame_deframer regression: fail");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    tx_gaps_on   = 1'b1;
    rx_quiet     = 1'b0;
    holdoff_req  = 1'b0;
    reset_frame_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed stream; typed rows carry their own expectation
    for (int i = 0; i < NUM_ROWS; i++)
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

    // Hold the receiver off while a long frame streams in back to back,
    // so both output registers fill and in_stall must rise
    tx_gaps_on = 1'b0;
    rx_mode(1'b0, 1'b1);
    send_frame(8'h82, 1'b1, FORM_SHORT, 64'd40, 40);
    tx_gaps_on = 1'b1;
    drain_results();

    // Random frames with idling on both sides
    while (sent_bytes < 180) send_random_frame();

    // Stretch with no idling on either side
    tx_gaps_on = 1'b0;
    rx_mode(1'b1, 1'b0);
    while (sent_bytes < 260) send_random_frame();
    tx_gaps_on = 1'b1;
    rx_mode(1'b0, 1'b0);

    while (sent_bytes < 330) send_random_frame();
    drain_results();
    while (sent_bytes < 420) send_random_frame();

    // Close on a 64-bit length with its top bit set; only part of it is sent
    send_frame(8'($urandom), 1'($urandom), FORM_EXT64,
               {1'b1, 31'($urandom), 32'($urandom)}, 12);

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("websocket_frame_deframer regression: pass");
    end else begin
      $display("websocket_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
